### design/srrip_pkg.sv
// ----------------------------------------------------------------------------
// SRRIP dead-block replacement package
// Shared widths, row types and the stride-entry layout.
// ----------------------------------------------------------------------------
package srrip_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int STRIDE_ENT   = 16;
    localparam int DECAY_LOG2   = 12;
    localparam int ADDR_BITS    = 48;

    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int WAY_W        = 4;
    localparam int SE_W         = $clog2(STRIDE_ENT);
    localparam int SIDX_W       = SET_W + SE_W;
    localparam int DELTA_W      = ADDR_BITS + 1;

    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [1:0] RRPV_INS = 2'd2;
    localparam logic [1:0] DEAD_MAX = 2'd3;

    typedef logic [2*NUM_WAYS-1:0] row_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           conf;
        logic [DELTA_W-1:0]   delta;
        logic [ADDR_BITS-1:0] addr;
    } stride_t;

    typedef struct packed {
        logic           seen;
        logic           wr_en;
        logic [SIDX_W-1:0] idx;
    } stride_res_t;

endpackage

### design/srrip_stride.sv
// ----------------------------------------------------------------------------
// SRRIP stride table
// Memory of stride entries; one read-modify-write per update word.
// ----------------------------------------------------------------------------
module srrip_stride (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [srrip_pkg::SIDX_W-1:0]    rd_idx,
    input  logic [srrip_pkg::ADDR_BITS-1:0] addr,
    input  logic                            wr_go,
    output logic                            clr_busy,
    output logic                            seen
);

    localparam int DEPTH = srrip_pkg::NUM_SETS * srrip_pkg::STRIDE_ENT;

    srrip_pkg::stride_t mem [DEPTH];
    srrip_pkg::stride_t rd_q;
    srrip_pkg::stride_t wr_d;
    logic [srrip_pkg::SIDX_W-1:0] idx_reg;
    logic [srrip_pkg::SIDX_W:0]   clr_reg;
    logic [srrip_pkg::DELTA_W-1:0] delta;
    logic same;

    assign clr_busy = !clr_reg[srrip_pkg::SIDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (clr_busy) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            idx_reg <= rd_idx;
            rd_q    <= mem[rd_idx];
        end
        if (clr_busy) begin
            mem[clr_reg[srrip_pkg::SIDX_W-1:0]] <= '0;
        end else if (wr_go) begin
            mem[idx_reg] <= wr_d;
        end
    end

    always_comb begin
        delta = {1'b0, addr} - {1'b0, rd_q.addr};
        same  = (delta == rd_q.delta);
        seen  = rd_q.valid && same && rd_q.conf[1];
        wr_d.valid = 1'b1;
        wr_d.addr  = addr;
        if (rd_q.valid) begin
            wr_d.delta = delta;
            if (same) begin
                wr_d.conf = (rd_q.conf == 2'd3) ? 2'd3 : rd_q.conf + 2'd1;
            end else begin
                wr_d.conf = (rd_q.conf == 2'd0) ? 2'd0 : rd_q.conf - 2'd1;
            end
        end else begin
            wr_d.delta = '0;
            wr_d.conf  = '0;
        end
    end

`ifndef ASSERT_OFF
    a_no_wr_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !wr_go) else $error("stride write during clear");
    a_seen_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        seen |-> rd_q.conf >= 2'd2) else $error("stream without confidence");
    a_clr_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_busy |=> !clr_busy) else $error("clear restarted");
`endif

endmodule

### design/srrip_meta.sv
// ----------------------------------------------------------------------------
// SRRIP block metadata
// Per-set RRPV and dead-counter rows with a background decay sweep.
// ----------------------------------------------------------------------------
module srrip_meta (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [srrip_pkg::SET_W-1:0]  rd_set,
    input  logic                         wr_go,
    input  logic                         is_upd,
    input  logic [srrip_pkg::WAY_W-1:0]  way,
    input  logic                         hit,
    input  logic                         seen,
    input  logic                         decay,
    output logic                         busy,
    output logic [srrip_pkg::WAY_W-1:0]  victim,
    output logic                         by_dead
);

    localparam int NW = srrip_pkg::NUM_WAYS;
    localparam int SW = srrip_pkg::SET_W;

    typedef struct packed {
        srrip_pkg::row_t  rrpv;
        srrip_pkg::row_t  dead;
    } mrow_t;

    mrow_t mem [srrip_pkg::NUM_SETS];
    mrow_t rd_q;
    mrow_t cur;
    mrow_t wr_d;
    srrip_pkg::row_t dec_dead;
    logic [SW-1:0]   set_reg;
    logic [SW:0]     clr_reg;
    logic            clr_busy;
    logic            swp_on_reg;
    logic [SW-1:0]   swp_cnt_reg;
    logic            swp_wv_reg;
    logic [SW-1:0]   swp_wa_reg;
    logic [SW-1:0]   rd_addr;
    logic [1:0] top;
    logic [1:0] add;
    logic [1:0] dv;
    logic [1:0] rv;
    logic found_d;

    assign clr_busy = !clr_reg[SW];
    assign busy     = clr_busy || swp_on_reg || swp_wv_reg;
    assign rd_addr  = swp_on_reg ? swp_cnt_reg : rd_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            swp_on_reg  <= 1'b0;
            swp_cnt_reg <= '0;
            swp_wv_reg  <= 1'b0;
        end else begin
            if (clr_busy) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (decay) begin
                swp_on_reg  <= 1'b1;
                swp_cnt_reg <= '0;
            end else if (swp_on_reg) begin
                swp_cnt_reg <= swp_cnt_reg + 1'b1;
                if (swp_cnt_reg == '1) begin
                    swp_on_reg <= 1'b0;
                end
            end
            swp_wv_reg <= swp_on_reg;
        end
    end

    // Sweep: read one row a cycle, write it back decayed in the next cycle, skipping the row in set_reg.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            set_reg <= rd_set;
        end
        if (swp_on_reg) begin
            swp_wa_reg <= swp_cnt_reg;
        end
        if (rd_en || swp_on_reg) begin
            rd_q <= mem[rd_addr];
        end
        if (clr_busy) begin
            mem[clr_reg[SW-1:0]] <= '{rrpv: '1, dead: '0};
        end else if (wr_go) begin
            mem[set_reg] <= wr_d;
        end else if (swp_wv_reg && (swp_wa_reg != set_reg)) begin
            mem[swp_wa_reg] <= '{rrpv: rd_q.rrpv, dead: dec_dead};
        end
    end

    always_comb begin
        for (int w = 0; w < NW; w++) begin
            dv = rd_q.dead[2*w +: 2];
            dec_dead[2*w +: 2] = (dv == 2'd0) ? 2'd0 : dv - 2'd1;
        end
        cur = rd_q;
        if (decay) begin
            cur.dead = dec_dead;
        end
        top = '0;
        for (int w = 0; w < NW; w++) begin
            if (cur.rrpv[2*w +: 2] > top) begin
                top = cur.rrpv[2*w +: 2];
            end
        end
        add = srrip_pkg::RRPV_MAX - top;
        wr_d = cur;
        victim  = '0;
        by_dead = 1'b0;
        found_d = 1'b0;
        rv = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (cur.dead[2*w +: 2] == srrip_pkg::DEAD_MAX) begin
                victim  = srrip_pkg::WAY_W'(w);
                found_d = 1'b1;
            end
        end
        if (!is_upd) begin
            if (found_d) begin
                by_dead = 1'b1;
            end else begin
                for (int w = 0; w < NW; w++) begin
                    wr_d.rrpv[2*w +: 2] = cur.rrpv[2*w +: 2] + add;
                end
                for (int w = NW - 1; w >= 0; w--) begin
                    if (cur.rrpv[2*w +: 2] == top) begin
                        victim = srrip_pkg::WAY_W'(w);
                    end
                end
            end
        end else begin
            victim = '0;
            if ({1'b0, way} < (srrip_pkg::WAY_W + 1)'(NW)) begin
                rv = cur.dead[2*way +: 2];
                if (hit) begin
                    wr_d.rrpv[2*way +: 2] = 2'd0;
                    wr_d.dead[2*way +: 2] = 2'd0;
                end else begin
                    wr_d.rrpv[2*way +: 2] = seen ? srrip_pkg::RRPV_MAX : srrip_pkg::RRPV_INS;
                    wr_d.dead[2*way +: 2] = (rv == srrip_pkg::DEAD_MAX) ? rv : rv + 2'd1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_wr_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !wr_go) else $error("meta write during clear or sweep");
    a_upd_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        is_upd |-> victim == '0 && !by_dead) else $error("update gave victim");
    a_decay_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        decay |-> !busy) else $error("decay during clear or sweep");
`endif

endmodule

### design/srrip_stream_dead_block_replacement_top.sv
// ----------------------------------------------------------------------------
// SRRIP stream dead-block replacement, top level
// Victim selection and metadata update for a 2048-set, 16-way cache.
// ----------------------------------------------------------------------------
// Input words on s_axis: a query (cmd 0) returns the victim way of a set;
// an update (cmd 1) records a hit or fill and reports a detected stream.
// Every input word yields exactly one output word on m_axis.
// The set row and the stride entry are read at the accepting edge; ST_READ
// holds the read data, and ST_MOD computes, writes back and loads the result
// register, from which m_tvalid rises. The next word is accepted in the cycle
// the result is taken, so a new word waits until the previous one has passed
// through ST_READ and ST_MOD and the metadata memories are written back.
// Every 4096th update decays its own row at once and then sweeps all other
// set rows, one read a cycle with each write-back in the cycle after its read:
// s_tready stays low until that sweep has finished after the update's result.
// After reset both memories are cleared one row a cycle: the 32768-entry stride
// table and, alongside it, the 2048 set rows, with s_tready low.
// When the receiver stalls, the result is held and new input is refused.
// ----------------------------------------------------------------------------
module srrip_stream_dead_block_replacement_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] cmd, [11:1] set_index, [15:12] way_index, [63:16] phys_address,
    // [64] was_hit, [71:65] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] victim_way, [4] by_dead_rule, [5] stream_seen, [7:6] zero
    output logic [7:0]  m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       busy_m;
    logic       busy_s;
    logic       acc;
    logic       cmd_reg;
    logic [srrip_pkg::WAY_W-1:0] way_reg;
    logic [srrip_pkg::ADDR_BITS-1:0] addr_reg;
    logic       hit_reg;
    logic [srrip_pkg::DECAY_LOG2-1:0] tick_reg;
    logic       decay;
    logic       seen;
    logic [srrip_pkg::WAY_W-1:0] victim;
    logic       by_dead;
    logic       out_v_reg;
    logic [7:0] out_reg;
    logic [srrip_pkg::SET_W-1:0] in_set;
    logic [srrip_pkg::ADDR_BITS-1:0] in_addr;
    logic [srrip_pkg::SIDX_W-1:0] s_idx;

    assign in_set  = s_tdata[1 +: srrip_pkg::SET_W];
    assign in_addr = s_tdata[16 +: srrip_pkg::ADDR_BITS];
    assign s_idx   = {in_set, in_addr[srrip_pkg::SE_W-1:0]};
    assign s_tready = (state_reg == ST_IDLE) && !busy_m && !busy_s
                      && (!out_v_reg || m_tready);
    assign acc   = s_tvalid && s_tready;
    assign decay = (state_reg == ST_MOD) && cmd_reg && (tick_reg == '1);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE: state_next = acc ? ST_READ : ST_IDLE;
            ST_READ: state_next = ST_MOD;
            ST_MOD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (decay || ((state_reg == ST_MOD) && cmd_reg)) begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (state_reg == ST_MOD) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg  <= s_tdata[0];
            way_reg  <= s_tdata[12 +: srrip_pkg::WAY_W];
            addr_reg <= in_addr;
            hit_reg  <= s_tdata[64];
        end
        if (state_reg == ST_MOD) begin
            out_reg <= {2'b00, cmd_reg & seen, by_dead, victim};
        end
    end

    srrip_stride u_stride (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_idx   (s_idx),
        .addr     (addr_reg),
        .wr_go    ((state_reg == ST_MOD) && cmd_reg),
        .clr_busy (busy_s),
        .seen     (seen)
    );

    srrip_meta u_meta (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (acc),
        .rd_set   (in_set),
        .wr_go    (state_reg == ST_MOD),
        .is_upd   (cmd_reg),
        .way      (way_reg),
        .hit      (hit_reg),
        .seen     (seen),
        .decay    (decay),
        .busy     (busy_m),
        .victim   (victim),
        .by_dead  (by_dead)
    );

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> state_reg == ST_READ) else $error("accept without read");
    a_mod_next: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOD |=> m_tvalid) else $error("result missing");
`endif

endmodule
